// ===== design/srg_pkg.sv =====
package srg_pkg;

  // Field widths (Q16.16 values, tick period and remaining time)
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned TICK_W  = 31;
  localparam int unsigned IN_W    = 72;  // 66 field bits padded to whole bytes
  localparam int unsigned OUT_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Divider: |target - input| << 16 over a positive 31-bit divisor
  localparam int unsigned NUM_W   = 49;
  localparam int unsigned DVS_W   = 31;
  localparam int unsigned CNT_W   = $clog2(NUM_W);

  // Slope magnitude (Q31.16 per second, saturated to 2^47 - 1) and step size
  localparam int unsigned SLOPE_W = 47;
  localparam int unsigned PHI_W   = SLOPE_W - 16 + TICK_W;  // high partial product
  localparam int unsigned PLO_W   = 16 + TICK_W;            // low partial product
  localparam int unsigned INC_W   = 34;

  localparam logic [DVS_W-1:0]  TEN_Q16   = DVS_W'(655360);
  localparam logic [VAL_W-1:0]  RATE_RST  = VAL_W'(655360);
  localparam logic [VAL_W-1:0]  DUR_RST   = VAL_W'(655360);
  localparam logic [TICK_W-1:0] TICK_RST  = TICK_W'(66);
  localparam logic [INC_W-1:0]  INC_CLAMP = INC_W'(64'h2_0000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_RATE,
    CFG_DURATION,
    CFG_TICK
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;       // take the input word
    logic eval;          // edge/pause/disable handling, change detect
    logic div_start;     // launch slope/remaining-time division
    logic restart_load;  // load quotient results, jump to input value
    logic adv_check;     // count down remaining time, form partial products
    logic adv_sum;       // add partial products, clamp increment
    logic adv_apply;     // saturating add to output
    logic load_out;      // load result word
  } srg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic restart;
    logic advance;
    logic div_busy;
    logic div_done;
    logic adv_finish;
  } srg_stat_t;

endpackage

// ===== design/srg_div.sv =====
module srg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [srg_pkg::NUM_W-1:0]   dividend,
  input  logic [srg_pkg::DVS_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [srg_pkg::NUM_W-1:0]   quotient
);

  localparam logic [srg_pkg::CNT_W-1:0] LAST = srg_pkg::CNT_W'(srg_pkg::NUM_W - 1);

  logic [srg_pkg::CNT_W-1:0] cnt;
  logic [srg_pkg::DVS_W-1:0] rem;
  logic [srg_pkg::DVS_W-1:0] dvs;
  logic [srg_pkg::NUM_W-1:0] quo;
  logic [srg_pkg::DVS_W:0]   trial;
  logic [srg_pkg::DVS_W:0]   trial_sub;
  logic                      fits;

  // restoring step: one quotient bit per cycle, MSB first
  assign trial     = {rem, quo[srg_pkg::NUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = trial >= {1'b0, dvs};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[srg_pkg::DVS_W-1:0] : trial[srg_pkg::DVS_W-1:0];
      quo <= {quo[srg_pkg::NUM_W-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

// ===== design/srg_datapath.sv =====
module srg_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srg_pkg::VAL_W-1:0]      cfg_data,
  input  logic [srg_pkg::IN_W-1:0]       in_word,
  input  srg_pkg::srg_cmd_t              cmd,
  output srg_pkg::srg_stat_t             st,
  output logic [srg_pkg::OUT_W-1:0]      out_word
);

  // configuration
  logic                        mode;
  logic [srg_pkg::VAL_W-1:0]   rate;
  logic [srg_pkg::VAL_W-1:0]   duration;
  logic [srg_pkg::TICK_W-1:0]  tick;

  // captured input word
  logic [srg_pkg::VAL_W-1:0]   in_val;
  logic                        en;
  logic                        pz;
  logic [srg_pkg::VAL_W-1:0]   end_val;

  // ramp state
  logic                        restart_pending;
  logic                        ramping;
  logic [srg_pkg::SLOPE_W-1:0] slope_mag;
  logic                        slope_neg;
  logic [srg_pkg::VAL_W-1:0]   out_reg;
  logic [srg_pkg::TICK_W-1:0]  remain;
  logic                        complete;
  logic                        enable_prev;
  logic [srg_pkg::VAL_W-1:0]   target_prev;
  logic                        mode_prev;
  logic [srg_pkg::VAL_W-1:0]   rate_prev;
  logic [srg_pkg::VAL_W-1:0]   duration_prev;

  // step arithmetic
  logic [srg_pkg::PHI_W-1:0]   prod_hi;
  logic [srg_pkg::PLO_W-1:0]   prod_lo;
  logic [srg_pkg::INC_W-1:0]   inc;
  logic [srg_pkg::PHI_W:0]     inc_sum;
  logic [srg_pkg::INC_W:0]     inc_signed;
  logic [srg_pkg::INC_W:0]     out_sum;

  // eval terms
  logic pend;
  logic pz_eff;
  logic ramp_eff;
  logic chg;
  logic restart_now;

  // restart terms
  logic [srg_pkg::VAL_W:0]     diff;
  logic [srg_pkg::VAL_W:0]     mag;
  logic [srg_pkg::DVS_W-1:0]   rate_eff;
  logic [srg_pkg::DVS_W-1:0]   dur_eff;
  logic [srg_pkg::NUM_W-1:0]   quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      rate     <= srg_pkg::RATE_RST;
      duration <= srg_pkg::DUR_RST;
      tick     <= srg_pkg::TICK_RST;
    end else if (cfg_we) begin
      unique case (srg_pkg::cfg_idx_t'(cfg_index))
        srg_pkg::CFG_MODE:     mode     <= cfg_data[0];
        srg_pkg::CFG_RATE:     rate     <= cfg_data;
        srg_pkg::CFG_DURATION: duration <= cfg_data;
        srg_pkg::CFG_TICK:     tick     <= cfg_data[srg_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_val  <= in_word[31:0];
      en      <= in_word[32];
      pz      <= in_word[33];
      end_val <= in_word[65:34];
    end
  end

  // tick decode: disable overrides pause; changes only count while ramping
  assign pend     = restart_pending | (en & ~enable_prev);
  assign pz_eff   = pz & en;
  assign ramp_eff = ramping & en;
  assign chg      = ramp_eff & ((mode != mode_prev) | (end_val != target_prev) |
                    (mode ? (rate != rate_prev) : (duration != duration_prev)));
  assign restart_now = ~pz_eff & (pend | chg);

  assign st.restart    = restart_now;
  assign st.advance    = ~pz_eff & (ramp_eff | restart_now);
  assign st.adv_finish = remain <= tick;

  // zero or negative rate/duration stands for 10.0
  assign rate_eff = (rate[srg_pkg::VAL_W-1] || rate == '0) ?
                    srg_pkg::TEN_Q16 : rate[srg_pkg::DVS_W-1:0];
  assign dur_eff  = (duration[srg_pkg::VAL_W-1] || duration == '0) ?
                    srg_pkg::TEN_Q16 : duration[srg_pkg::DVS_W-1:0];

  assign diff = {end_val[srg_pkg::VAL_W-1], end_val} - {in_val[srg_pkg::VAL_W-1], in_val};
  assign mag  = diff[srg_pkg::VAL_W] ? (~diff + 1'b1) : diff;

  srg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({mag, 16'h0000}),
    .divisor  (mode ? rate_eff : dur_eff),
    .busy     (st.div_busy),
    .done     (st.div_done),
    .quotient (quotient)
  );

  assign inc_sum    = {1'b0, prod_hi} + (srg_pkg::PHI_W + 1)'(prod_lo[srg_pkg::PLO_W-1:16]);
  assign inc_signed = slope_neg ? (~{1'b0, inc} + 1'b1) : {1'b0, inc};
  assign out_sum    = {{(srg_pkg::INC_W + 1 - srg_pkg::VAL_W){out_reg[srg_pkg::VAL_W-1]}},
                       out_reg} + inc_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      restart_pending <= 1'b0;
      ramping         <= 1'b0;
      slope_mag       <= '0;
      slope_neg       <= 1'b0;
      out_reg         <= '0;
      remain          <= '0;
      complete        <= 1'b0;
      enable_prev     <= 1'b0;
      target_prev     <= '0;
      mode_prev       <= 1'b0;
      rate_prev       <= '0;
      duration_prev   <= '0;
    end else begin
      if (cmd.eval) begin
        if (!en) begin
          complete <= 1'b0;
          remain   <= '0;
          ramping  <= 1'b0;
          out_reg  <= in_val;
        end
        if (pz_eff) begin
          restart_pending <= pend;
        end else begin
          restart_pending <= 1'b0;
          enable_prev     <= en;
          target_prev     <= end_val;
          mode_prev       <= mode;
          rate_prev       <= rate;
          duration_prev   <= duration;
        end
      end
      if (cmd.div_start) begin
        slope_neg <= diff[srg_pkg::VAL_W];
      end
      if (cmd.restart_load) begin
        ramping  <= 1'b1;
        complete <= 1'b0;
        out_reg  <= in_val;
        if (mode) begin
          slope_mag <= srg_pkg::SLOPE_W'(rate_eff);
          remain    <= (|quotient[srg_pkg::NUM_W-1:srg_pkg::TICK_W]) ?
                       '1 : quotient[srg_pkg::TICK_W-1:0];
        end else begin
          slope_mag <= (|quotient[srg_pkg::NUM_W-1:srg_pkg::SLOPE_W]) ?
                       '1 : quotient[srg_pkg::SLOPE_W-1:0];
          remain    <= dur_eff;
        end
      end
      if (cmd.adv_check) begin
        if (st.adv_finish) begin
          remain   <= '0;
          out_reg  <= end_val;
          complete <= 1'b1;
        end else begin
          remain <= remain - tick;
        end
      end
      if (cmd.adv_apply) begin
        complete <= 1'b0;
        if (out_sum[srg_pkg::INC_W:srg_pkg::VAL_W-1] == '0 ||
            out_sum[srg_pkg::INC_W:srg_pkg::VAL_W-1] == '1) begin
          out_reg <= out_sum[srg_pkg::VAL_W-1:0];
        end else if (out_sum[srg_pkg::INC_W]) begin
          out_reg <= {1'b1, {(srg_pkg::VAL_W-1){1'b0}}};
        end else begin
          out_reg <= {1'b0, {(srg_pkg::VAL_W-1){1'b1}}};
        end
      end
    end
  end

  // step size: (|slope| >> 16) * tick + ((|slope| & 0xFFFF) * tick >> 16)
  always_ff @(posedge clk) begin
    if (cmd.adv_check) begin
      prod_hi <= slope_mag[srg_pkg::SLOPE_W-1:16] * tick;
      prod_lo <= slope_mag[15:0] * tick;
    end
    if (cmd.adv_sum) begin
      inc <= (inc_sum > (srg_pkg::PHI_W + 1)'(srg_pkg::INC_CLAMP)) ?
             srg_pkg::INC_CLAMP : inc_sum[srg_pkg::INC_W-1:0];
    end
    if (cmd.load_out) begin
      out_word <= {remain, complete, out_reg};
    end
  end

  a_complete_state: assert property (@(posedge clk) disable iff (rst)
      complete |-> (remain == '0 && ramping))
    else $error("complete set with time left or while not ramping");

endmodule

// ===== design/srg_ctrl.sv =====
module srg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  output logic               m_valid,
  input  logic               m_ready,
  input  srg_pkg::srg_stat_t st,
  output srg_pkg::srg_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_LOAD,
    ST_ADV_CHK,
    ST_ADV_SUM,
    ST_ADV_APPLY,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = ~m_valid | m_ready;
  assign s_ready   = state == ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_valid;
        if (s_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.div_start = st.restart;
        priority if (st.restart) state_next = ST_DIV;
        else if (st.advance)     state_next = ST_ADV_CHK;
        else                     state_next = ST_EMIT;
      end
      ST_DIV: begin
        if (st.div_done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.restart_load = 1'b1;
        state_next       = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        cmd.adv_check = 1'b1;
        state_next    = st.adv_finish ? ST_EMIT : ST_ADV_SUM;
      end
      ST_ADV_SUM: begin
        cmd.adv_sum = 1'b1;
        state_next  = ST_ADV_APPLY;
      end
      ST_ADV_APPLY: begin
        cmd.adv_apply = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.load_out = slot_free;
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
      cmd.load_out |-> (!m_valid || m_ready))
    else $error("result word overwritten before it was taken");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV) |-> (st.div_busy || st.div_done))
    else $error("waiting on a divider that is not running");

  a_div_launch: assert property (@(posedge clk) disable iff (rst)
      cmd.div_start |=> st.div_busy)
    else $error("division did not start");

endmodule

// ===== design/setpoint_ramp_generator_core.sv =====
// Channel  Dir  Handshake        Word layout (LSB first)
// s_axis   in   tvalid/tready    in_value[31:0] enable[32] pause[33] target[65:34] pad[71:66]
// m_axis   out  tvalid/tready    out_value[31:0] complete[32] time_left[63:33]
// cfg      in   cfg_we, no wait  index 0 mode, 1 rate, 2 duration, 3 tick period
//
// One word in, one word out, one word at a time. A stepping tick runs accept, evaluate,
// three step stages and output load; a tick that ends the ramp leaves out the add and apply
// stages, a tick with no ramp all three. A restart adds the serial divider (49 quotient
// bits, then its done flag) and a load state that precedes the step stages.
// A stalled output holds the block in output load; the next word is accepted once the
// result sits in the output register. rst (synchronous) restores defaults, clears the ramp.
module setpoint_ramp_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // in_value[31:0], enable[32], pause[33], target[65:34], zero pad[71:66]
  input  logic [srg_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_value[31:0], complete[32], time_left[63:33]
  output logic [srg_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [srg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srg_pkg::VAL_W-1:0]      cfg_data
);

  srg_pkg::srg_cmd_t  cmd;
  srg_pkg::srg_stat_t st;

  // sequencer: accept, evaluate, divide on restart, step, present result
  srg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  // registers, ramp state, divider, step arithmetic and the result register
  srg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_word  (m_axis_tdata)
  );

endmodule
